### src/bdrp_pkg.sv
// ----------------------------------------------------------------------------
// bdrp_pkg
// Shared types, codes and constants of the block disk register port.
// ----------------------------------------------------------------------------
package bdrp_pkg;

   // Disk geometry
   localparam int BLOCK_BYTES    = 512;
   localparam int OFFSET_W       = $clog2(BLOCK_BYTES);
   localparam int MAX_BLOCKS_DEF = 64;

   // Field widths
   localparam int DATA_W     = 8;
   localparam int SLOT_W     = 4;
   localparam int SEL_W      = 16;
   localparam int COUNT_W    = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   // Access kinds
   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   // Register slots on the bus
   localparam logic [SLOT_W-1:0] SLOT_SEL_LO   = 4'd0;
   localparam logic [SLOT_W-1:0] SLOT_SEL_HI   = 4'd1;
   localparam logic [SLOT_W-1:0] SLOT_DATA     = 4'd2;
   localparam logic [SLOT_W-1:0] SLOT_STATUS   = 4'd3;
   localparam logic [SLOT_W-1:0] SLOT_COUNT_LO = 4'd4;
   localparam logic [SLOT_W-1:0] SLOT_COUNT_HI = 4'd5;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_COUNT   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_PROTECT = 1'd1;

   // Data constants
   localparam logic [DATA_W-1:0] NO_DATA        = 8'hFF;
   localparam logic [DATA_W-1:0] WRITE_ACK      = 8'h00;
   localparam logic [DATA_W-1:0] STATUS_NO_DISK = 8'h80;
   localparam logic [DATA_W-1:0] STATUS_WPROT   = 8'h40;
   localparam logic [SEL_W-1:0]  COUNT_CLAMP    = 16'hFFFF;

   // Memory access issued for one item
   typedef struct packed {
      logic rd;
      logic wr;
   } mem_op_type;

   // Item in flight between accept and the response queue
   typedef struct packed {
      logic              valid;
      logic              use_mem;
      logic [DATA_W-1:0] value;
   } stage_type;

endpackage

### src/bdrp_store.sv
// ----------------------------------------------------------------------------
// bdrp_store
// Disk byte store: single-port synchronous memory with registered read data
// and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module bdrp_store #(
   parameter int MAX_BLOCKS = bdrp_pkg::MAX_BLOCKS_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  bdrp_pkg::mem_op_type                              mem_op,
   input  logic [$clog2(MAX_BLOCKS*bdrp_pkg::BLOCK_BYTES)-1:0] mem_addr,
   input  logic [bdrp_pkg::DATA_W-1:0]                       mem_wdata,
   output logic [bdrp_pkg::DATA_W-1:0]                       mem_rdata,
   output logic                                              clear_busy
);

   localparam int DEPTH  = MAX_BLOCKS * bdrp_pkg::BLOCK_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [bdrp_pkg::DATA_W-1:0] store_ff [DEPTH];
   logic [bdrp_pkg::DATA_W-1:0] rdata_ff;
   logic                        clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0]           clr_addr_ff, clr_addr_in;

   // Advance the clearing sweep, one byte per cycle
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // Write port: sweep has priority, no items are taken while it runs
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         store_ff[clr_addr_ff] <= '0;
      end else if (mem_op.wr) begin
         store_ff[mem_addr] <= mem_wdata;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (mem_op.rd) begin
         rdata_ff <= store_ff[mem_addr];
      end
   end

   assign mem_rdata  = rdata_ff;
   assign clear_busy = clr_busy_ff;

endmodule

### src/bdrp_ctrl.sv
// ----------------------------------------------------------------------------
// bdrp_ctrl
// Access decoder: holds block select, byte offset and configuration, issues
// the store access and stages the response of each accepted item.
// ----------------------------------------------------------------------------
module bdrp_ctrl #(
   parameter int MAX_BLOCKS = bdrp_pkg::MAX_BLOCKS_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              req_take,
   input  logic                                              req_cmd,
   input  logic [bdrp_pkg::SLOT_W-1:0]                       req_reg_index,
   input  logic [bdrp_pkg::DATA_W-1:0]                       req_write_data,
   input  logic                                              csr_take,
   input  logic [bdrp_pkg::CSR_IDX_W-1:0]                    csr_index,
   input  logic [bdrp_pkg::CSR_DATA_W-1:0]                   csr_write_data,
   output bdrp_pkg::mem_op_type                              mem_op,
   output logic [$clog2(MAX_BLOCKS*bdrp_pkg::BLOCK_BYTES)-1:0] mem_addr,
   output logic [bdrp_pkg::DATA_W-1:0]                       mem_wdata,
   output bdrp_pkg::stage_type                               stage
);

   localparam int ADDR_W = $clog2(MAX_BLOCKS * bdrp_pkg::BLOCK_BYTES);

   logic [bdrp_pkg::SEL_W-1:0]    sel_ff, sel_in;
   logic [bdrp_pkg::OFFSET_W-1:0] off_ff, off_in;
   logic [bdrp_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic                          wprot_ff, wprot_in;
   bdrp_pkg::stage_type           stage_ff, stage_in;

   logic [bdrp_pkg::COUNT_W-1:0] nblk;
   logic [bdrp_pkg::SEL_W-1:0]   count16;
   logic                         has_disk;
   logic                         in_range;

   // Effective block count, limited by the store capacity
   always_comb begin
      if (int'(count_ff) > MAX_BLOCKS) begin
         nblk = bdrp_pkg::COUNT_W'(MAX_BLOCKS);
      end else begin
         nblk = count_ff;
      end
      if (bdrp_pkg::SEL_W'(nblk) > bdrp_pkg::COUNT_CLAMP) begin
         count16 = bdrp_pkg::COUNT_CLAMP;
      end else begin
         count16 = bdrp_pkg::SEL_W'(nblk);
      end
   end

   assign has_disk  = (nblk != '0);
   assign in_range  = (sel_ff < bdrp_pkg::SEL_W'(nblk));
   assign mem_addr  = ADDR_W'({sel_ff, off_ff});
   assign mem_wdata = req_write_data;

   // Configuration writes
   always_comb begin
      count_in = count_ff;
      wprot_in = wprot_ff;
      if (csr_take) begin
         unique case (csr_index)
            bdrp_pkg::CSR_BLOCK_COUNT:   count_in = csr_write_data;
            bdrp_pkg::CSR_WRITE_PROTECT: wprot_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   // Decode one access
   always_comb begin
      sel_in           = sel_ff;
      off_in           = off_ff;
      mem_op           = '0;
      stage_in.valid   = req_take;
      stage_in.use_mem = 1'b0;
      stage_in.value   = bdrp_pkg::NO_DATA;
      if (req_take) begin
         if (req_cmd == bdrp_pkg::CMD_WRITE) begin
            stage_in.value = bdrp_pkg::WRITE_ACK;
            unique case (req_reg_index)
               bdrp_pkg::SLOT_SEL_LO: begin
                  sel_in = {sel_ff[15:8], req_write_data};
                  off_in = '0;
               end
               bdrp_pkg::SLOT_SEL_HI: begin
                  sel_in = {req_write_data, sel_ff[7:0]};
                  off_in = '0;
               end
               bdrp_pkg::SLOT_DATA: begin
                  if (has_disk && !wprot_ff) begin
                     mem_op.wr = in_range;
                     off_in    = off_ff + bdrp_pkg::OFFSET_W'(1);
                  end
               end
               default: ;
            endcase
         end else begin
            unique case (req_reg_index)
               bdrp_pkg::SLOT_DATA: begin
                  if (has_disk) begin
                     mem_op.rd        = in_range;
                     stage_in.use_mem = in_range;
                     off_in           = off_ff + bdrp_pkg::OFFSET_W'(1);
                  end
               end
               bdrp_pkg::SLOT_STATUS: begin
                  stage_in.value = (has_disk ? '0 : bdrp_pkg::STATUS_NO_DISK)
                                 | (wprot_ff ? bdrp_pkg::STATUS_WPROT : '0);
               end
               bdrp_pkg::SLOT_COUNT_LO: stage_in.value = count16[7:0];
               bdrp_pkg::SLOT_COUNT_HI: stage_in.value = count16[15:8];
               default: ;
            endcase
         end
      end
   end

   // Hold control state; the staged payload needs no reset
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff         <= '0;
         off_ff         <= '0;
         count_ff       <= '0;
         wprot_ff       <= 1'b0;
         stage_ff.valid <= 1'b0;
      end else begin
         sel_ff         <= sel_in;
         off_ff         <= off_in;
         count_ff       <= count_in;
         wprot_ff       <= wprot_in;
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.use_mem <= stage_in.use_mem;
      stage_ff.value   <= stage_in.value;
   end

   assign stage = stage_ff;

endmodule

### src/bdrp_rsp_fifo.sv
// ----------------------------------------------------------------------------
// bdrp_rsp_fifo
// Four-entry response queue that parts the store pipeline from the receiver.
// ----------------------------------------------------------------------------
module bdrp_rsp_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [bdrp_pkg::DATA_W-1:0] push_data,
   input  logic                        pop,
   output logic                        head_valid,
   output logic [bdrp_pkg::DATA_W-1:0] head_data,
   output logic [2:0]                  fill
);

   logic [bdrp_pkg::DATA_W-1:0] entry_ff [4];
   logic [1:0]                  wr_ptr_ff, wr_ptr_in;
   logic [1:0]                  rd_ptr_ff, rd_ptr_in;
   logic [2:0]                  cnt_ff, cnt_in;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + 2'(push);
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      cnt_in    = cnt_ff + 3'(push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (cnt_ff != '0);
   assign head_data  = entry_ff[rd_ptr_ff];
   assign fill       = cnt_ff;

endmodule

### src/block_disk_register_port.sv
// ----------------------------------------------------------------------------
// block_disk_register_port
// Bus register port of a block disk backed by an on-chip byte store.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one bus access per item (cmd, reg_index, write_data); taken at a
//            clock edge with req_valid high and req_stall low.
//   rsp_*  : exactly one read_data item per access, in order; taken at an
//            edge with rsp_valid high and rsp_stall low. Writes answer zero.
//   csr_*  : configuration writes (index 0 block count, 1 write protect);
//            csr_ready is always high, so writes are taken at once.
// Flow: an accepted item is registered in the stage register, then pushed into
//   the response queue and offered on rsp_*. One item per cycle is taken while
//   req_stall is low; the single store port reads or writes one byte per item.
// Up to three items are held inside (in the store read stage and a four-entry
//   response queue); req_stall rises when three are held, so a stalled
//   receiver halts the requester after three items.
// Reset: select and offset return to zero and the configuration clears. The
//   store is then swept to zero at one byte per cycle over all MAX_BLOCKS * 512
//   bytes (32768 by default), with req_stall held high.
// ----------------------------------------------------------------------------
module block_disk_register_port #(
   parameter int MAX_BLOCKS = bdrp_pkg::MAX_BLOCKS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_cmd,
   input  logic [bdrp_pkg::SLOT_W-1:0]     req_reg_index,
   input  logic [bdrp_pkg::DATA_W-1:0]     req_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bdrp_pkg::DATA_W-1:0]     rsp_read_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bdrp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bdrp_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int ADDR_W = $clog2(MAX_BLOCKS * bdrp_pkg::BLOCK_BYTES);

   bdrp_pkg::mem_op_type        mem_op;
   logic [ADDR_W-1:0]           mem_addr;
   logic [bdrp_pkg::DATA_W-1:0] mem_wdata;
   logic [bdrp_pkg::DATA_W-1:0] mem_rdata;
   bdrp_pkg::stage_type         stage;
   logic                        clear_busy;
   logic                        req_take;
   logic                        rsp_take;
   logic [bdrp_pkg::DATA_W-1:0] push_data;
   logic [2:0]                  fill;
   logic [1:0]                  inflight_ff, inflight_in;

   // Accept only with room for the item's response
   assign req_stall = clear_busy || (inflight_ff == 2'd3);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign csr_ready = 1'b1;

   // Count items between accept and delivery
   always_comb begin
      inflight_in = inflight_ff + 2'(req_take) - 2'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   bdrp_ctrl #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_take       (req_take),
      .req_cmd        (req_cmd),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .csr_take       (csr_valid && csr_ready),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .mem_op         (mem_op),
      .mem_addr       (mem_addr),
      .mem_wdata      (mem_wdata),
      .stage          (stage)
   );

   bdrp_store #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .mem_op     (mem_op),
      .mem_addr   (mem_addr),
      .mem_wdata  (mem_wdata),
      .mem_rdata  (mem_rdata),
      .clear_busy (clear_busy)
   );

   // Pick store data or the decoded byte for the staged item
   assign push_data = stage.use_mem ? mem_rdata : stage.value;

   bdrp_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (stage.valid),
      .push_data  (push_data),
      .pop        (rsp_take),
      .head_valid (rsp_valid),
      .head_data  (rsp_read_data),
      .fill       (fill)
   );

   // Staged item always finds room in the response queue
   assert property (@(posedge clock) disable iff (reset)
      !(stage.valid && (fill == 3'd4) && !rsp_take))
      else $error("response queue overflow");

   // Credit count matches items actually held
   assert property (@(posedge clock) disable iff (reset)
      {1'b0, inflight_ff} == (3'(stage.valid) + fill))
      else $error("in-flight count mismatch");

   // No store access from the decoder during the clearing sweep
   assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !(mem_op.rd || mem_op.wr))
      else $error("store access during clear");

   // A store read is followed by its staged item
   assert property (@(posedge clock) disable iff (reset)
      mem_op.rd |=> (stage.valid && stage.use_mem))
      else $error("store read not staged");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Bus accesses to the block disk register port, checked against a predictor.
// A directed part covers no disk, the last block, an out-of-range block and
// the unused slots. Random phases follow under several disk sizes and
// write-protect settings, mostly as select, write burst, rewind, read back.
// Both sides idle at random, and every read_data is checked in order.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_BLK     = bdrp_pkg::MAX_BLOCKS_DEF;
   localparam int IMG_BYTES   = MAX_BLK * bdrp_pkg::BLOCK_BYTES;
   localparam int GAP_MAX     = 17;
   localparam int PHASE_ITEMS = 105;
   localparam int CYCLE_LIMIT = 500000;
   localparam logic [bdrp_pkg::SLOT_W-1:0] SLOT_LAST = 4'd15;

   typedef struct packed {
      logic                        cmd;
      logic [bdrp_pkg::SLOT_W-1:0] slot;
      logic [bdrp_pkg::DATA_W-1:0] wdata;
   } bus_access_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_cmd = bdrp_pkg::CMD_READ;
   logic [bdrp_pkg::SLOT_W-1:0]     req_reg_index = bdrp_pkg::SLOT_SEL_LO;
   logic [bdrp_pkg::DATA_W-1:0]     req_write_data = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [bdrp_pkg::DATA_W-1:0]     rsp_read_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [bdrp_pkg::CSR_IDX_W-1:0]  csr_index = bdrp_pkg::CSR_BLOCK_COUNT;
   logic [bdrp_pkg::CSR_DATA_W-1:0] csr_write_data = '0;

   // Predicted disk state and configuration
   logic [bdrp_pkg::DATA_W-1:0]   disk_img [IMG_BYTES];
   logic [bdrp_pkg::SEL_W-1:0]    sel_blk;
   logic [bdrp_pkg::OFFSET_W-1:0] byte_off;
   logic [bdrp_pkg::COUNT_W-1:0]  blk_count;
   logic                          wr_prot;

   bus_access_type              pend_q [$];
   logic [bdrp_pkg::DATA_W-1:0] read_expect_q [$];
   int unsigned                 gen_total = 0;
   int unsigned                 fail_count = 0;
   int unsigned                 cycle_count = 0;
   int unsigned                 req_gap = 0;
   int unsigned                 rsp_hold = 0;
   logic                        quiet = 1'b0;

   block_disk_register_port dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one access to the predicted disk and return the byte it reads back
   function automatic logic [bdrp_pkg::DATA_W-1:0] bus_access(
         logic cmd, logic [bdrp_pkg::SLOT_W-1:0] slot, logic [bdrp_pkg::DATA_W-1:0] wdata);
      int unsigned                 nblk;
      int unsigned                 addr;
      logic                        hit;
      logic [bdrp_pkg::SEL_W-1:0]  cnt16;
      logic [bdrp_pkg::DATA_W-1:0] r;
      nblk  = (blk_count > MAX_BLK) ? MAX_BLK : blk_count;
      hit   = (sel_blk < nblk);
      addr  = sel_blk * bdrp_pkg::BLOCK_BYTES + byte_off;
      cnt16 = (nblk > bdrp_pkg::COUNT_CLAMP) ? bdrp_pkg::COUNT_CLAMP
                                             : nblk[bdrp_pkg::SEL_W-1:0];
      r     = bdrp_pkg::NO_DATA;
      if (cmd == bdrp_pkg::CMD_WRITE) begin
         r = bdrp_pkg::WRITE_ACK;
         case (slot)
            bdrp_pkg::SLOT_SEL_LO: begin
               sel_blk[7:0] = wdata;
               byte_off = '0;
            end
            bdrp_pkg::SLOT_SEL_HI: begin
               sel_blk[15:8] = wdata;
               byte_off = '0;
            end
            bdrp_pkg::SLOT_DATA: begin
               // protected or absent disk: drop the byte, hold the offset
               if (nblk != 0 && !wr_prot) begin
                  if (hit)
                     disk_img[addr] = wdata;
                  byte_off = byte_off + 1'b1;
               end
            end
            default: ;
         endcase
      end else begin
         case (slot)
            bdrp_pkg::SLOT_DATA: begin
               if (nblk != 0) begin
                  if (hit)
                     r = disk_img[addr];
                  byte_off = byte_off + 1'b1;
               end
            end
            bdrp_pkg::SLOT_STATUS:
               r = (nblk == 0 ? bdrp_pkg::STATUS_NO_DISK : 8'h00) |
                   (wr_prot ? bdrp_pkg::STATUS_WPROT : 8'h00);
            bdrp_pkg::SLOT_COUNT_LO: r = cnt16[7:0];
            bdrp_pkg::SLOT_COUNT_HI: r = cnt16[15:8];
            default: ;
         endcase
      end
      return r;
   endfunction

   // Driver: predict each accepted item, then present the next one after its gap
   always @(posedge clock) begin : drive_proc
      int unsigned    gap_n;
      logic           taken;
      bus_access_type nxt;
      gap_n = req_gap;
      taken = req_valid && !req_stall;
      if (taken) begin
         read_expect_q.push_back(bus_access(req_cmd, req_reg_index, req_write_data));
         gap_n = quiet ? 0 : $urandom_range(0, GAP_MAX);
         if ($urandom_range(0, 39) == 0)
            quiet <= !quiet;
      end
      if (!req_valid || taken) begin
         if (gap_n != 0) begin
            gap_n = gap_n - 1;
            req_valid <= 1'b0;
         end else if (pend_q.size() != 0) begin
            nxt = pend_q.pop_front();
            req_cmd        <= nxt.cmd;
            req_reg_index  <= nxt.slot;
            req_write_data <= nxt.wdata;
            req_valid      <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      req_gap <= gap_n;
   end

   // Monitor: check each accepted item against the oldest prediction, then may stall at random
   always @(posedge clock) begin : monitor_proc
      int unsigned                 hold_n;
      logic [bdrp_pkg::DATA_W-1:0] want;
      hold_n = (rsp_hold != 0) ? rsp_hold - 1 : 0;
      if (rsp_valid && !rsp_stall) begin
         if (read_expect_q.size() == 0) begin
            $display("%0t: unexpected item, read_data %02h", $time, rsp_read_data);
            fail_count = fail_count + 1;
         end else begin
            want = read_expect_q.pop_front();
            if (rsp_read_data !== want) begin
               $display("%0t: read_data expected %02h, actual %02h",
                        $time, want, rsp_read_data);
               fail_count = fail_count + 1;
            end
         end
         hold_n = quiet ? 0 : $urandom_range(0, GAP_MAX);
      end
      rsp_hold  <= hold_n;
      rsp_stall <= (hold_n != 0);
   end

   // Guard against a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d items still expected", $time, read_expect_q.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_access(logic cmd, logic [bdrp_pkg::SLOT_W-1:0] slot,
                              logic [bdrp_pkg::DATA_W-1:0] wdata);
      pend_q.push_back(bus_access_type'{cmd, slot, wdata});
      gen_total = gen_total + 1;
   endtask

   // Write one configuration register and mirror it once taken
   task automatic csr_put(logic [bdrp_pkg::CSR_IDX_W-1:0] idx,
                          logic [bdrp_pkg::CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_index      <= idx;
      csr_write_data <= val;
      csr_valid      <= 1'b1;
      do
         @(posedge clock);
      while (!csr_ready);
      if (idx == bdrp_pkg::CSR_BLOCK_COUNT)
         blk_count = val;
      else
         wr_prot = val[0];
      csr_valid <= 1'b0;
   endtask

   task automatic set_disk(int unsigned count, logic wp);
      logic [bdrp_pkg::CSR_DATA_W-1:0] wp_word;
      wp_word = {6'($urandom_range(0, 63)), wp};
      csr_put(bdrp_pkg::CSR_BLOCK_COUNT, count[bdrp_pkg::CSR_DATA_W-1:0]);
      csr_put(bdrp_pkg::CSR_WRITE_PROTECT, wp_word);
      @(negedge clock);
   endtask

   // Wait until every item is driven and answered, then let the pipe settle
   task automatic settle();
      while (pend_q.size() != 0 || req_valid || read_expect_q.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Select a block, mostly near the disk size, sometimes anywhere
   task automatic pick_block(int unsigned count, output logic [bdrp_pkg::DATA_W-1:0] lo);
      int unsigned                 eff;
      logic [bdrp_pkg::DATA_W-1:0] hi;
      eff = (count > MAX_BLK) ? MAX_BLK : count;
      lo  = ($urandom_range(0, 3) == 0) ? bdrp_pkg::DATA_W'($urandom_range(0, 255))
                                        : bdrp_pkg::DATA_W'($urandom_range(0, eff));
      hi  = ($urandom_range(0, 7) == 0) ? bdrp_pkg::DATA_W'($urandom_range(1, 255))
                                        : '0;
      if ($urandom_range(0, 1) != 0) begin
         push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_SEL_HI, hi);
         push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_SEL_LO, lo);
      end else begin
         push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_SEL_LO, lo);
         push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_SEL_HI, hi);
      end
   endtask

   task automatic random_sequence(int unsigned count);
      int unsigned                 kind;
      int unsigned                 len;
      logic [bdrp_pkg::DATA_W-1:0] lo;
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
         // write a burst, rewind, read it back
         pick_block(count, lo);
         len = $urandom_range(1, 12);
         repeat (len)
            push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_DATA,
                        bdrp_pkg::DATA_W'($urandom_range(0, 255)));
         push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_SEL_LO, lo);
         repeat (len + $urandom_range(0, 2))
            push_access(bdrp_pkg::CMD_READ, bdrp_pkg::SLOT_DATA,
                        bdrp_pkg::DATA_W'($urandom_range(0, 255)));
      end else if (kind <= 7) begin
         repeat ($urandom_range(1, 4))
            push_access(bdrp_pkg::CMD_READ,
                        bdrp_pkg::SLOT_W'($urandom_range(bdrp_pkg::SLOT_STATUS,
                                                         bdrp_pkg::SLOT_COUNT_HI)),
                        bdrp_pkg::DATA_W'($urandom_range(0, 255)));
      end else if (kind == 8) begin
         repeat ($urandom_range(1, 4))
            push_access(1'($urandom_range(0, 1)), bdrp_pkg::SLOT_W'($urandom_range(0, 15)),
                        bdrp_pkg::DATA_W'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(1, 16))
            push_access(1'($urandom_range(0, 1)), bdrp_pkg::SLOT_DATA,
                        bdrp_pkg::DATA_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin : main_seq
      int unsigned                 phase_cnt [5] = '{127, 1, 64, 65, 0};
      logic                        phase_wp  [5] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
      int unsigned                 cnt;
      int unsigned                 start;
      logic                        wp;
      logic [bdrp_pkg::DATA_W-1:0] lo;
      for (int i = 0; i < IMG_BYTES; i++)
         disk_img[i] = '0;
      sel_blk   = '0;
      byte_off  = '0;
      blk_count = '0;
      wr_prot   = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // No disk: data port dead, status flags it, unused slots read all ones
      set_disk(0, 1'b0);
      push_access(bdrp_pkg::CMD_READ,  bdrp_pkg::SLOT_DATA,     8'h00);
      push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_DATA,     8'hFF);
      push_access(bdrp_pkg::CMD_READ,  bdrp_pkg::SLOT_STATUS,   8'hFF);
      push_access(bdrp_pkg::CMD_READ,  bdrp_pkg::SLOT_COUNT_LO, 8'h00);
      push_access(bdrp_pkg::CMD_READ,  bdrp_pkg::SLOT_COUNT_HI, 8'h00);
      push_access(bdrp_pkg::CMD_READ,  bdrp_pkg::SLOT_SEL_LO,   8'h00);
      push_access(bdrp_pkg::CMD_READ,  SLOT_LAST,               8'hFF);
      push_access(bdrp_pkg::CMD_WRITE, SLOT_LAST,               8'hFF);
      settle();

      // Full disk: last block, then an out-of-range block, then back
      set_disk(MAX_BLK, 1'b0);
      push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_SEL_LO,
                  bdrp_pkg::DATA_W'(MAX_BLK - 1));
      push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_SEL_HI,   8'h00);
      push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_DATA,     8'hFF);
      push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_DATA,     8'h00);
      push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_DATA,     8'h5A);
      push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_SEL_LO,
                  bdrp_pkg::DATA_W'(MAX_BLK - 1));
      repeat (3) push_access(bdrp_pkg::CMD_READ, bdrp_pkg::SLOT_DATA, 8'h00);
      push_access(bdrp_pkg::CMD_READ,  bdrp_pkg::SLOT_STATUS,   8'h00);
      push_access(bdrp_pkg::CMD_READ,  bdrp_pkg::SLOT_COUNT_LO, 8'h00);
      push_access(bdrp_pkg::CMD_READ,  bdrp_pkg::SLOT_COUNT_HI, 8'h00);
      push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_SEL_HI,   8'hFF);
      push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_DATA,     8'h11);
      push_access(bdrp_pkg::CMD_READ,  bdrp_pkg::SLOT_DATA,     8'h00);
      push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_SEL_HI,   8'h00);
      push_access(bdrp_pkg::CMD_READ,  bdrp_pkg::SLOT_DATA,     8'h00);
      settle();

      // Random phases over several disk sizes and protect settings
      for (int p = 0; p < 8; p++) begin
         cnt = (p < 5) ? phase_cnt[p] : $urandom_range(0, 127);
         wp  = (p < 5) ? phase_wp[p] : 1'($urandom_range(0, 1));
         set_disk(cnt, wp);
         if (p == 2) begin
            // run the offset past the block end, then read the wrapped bytes
            lo = bdrp_pkg::DATA_W'($urandom_range(0, MAX_BLK - 1));
            push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_SEL_HI, 8'h00);
            push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_SEL_LO, lo);
            repeat (bdrp_pkg::BLOCK_BYTES + 2)
               push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_DATA,
                           bdrp_pkg::DATA_W'($urandom_range(0, 255)));
            push_access(bdrp_pkg::CMD_WRITE, bdrp_pkg::SLOT_SEL_LO, lo);
            repeat (6) push_access(bdrp_pkg::CMD_READ, bdrp_pkg::SLOT_DATA, 8'h00);
         end
         start = gen_total;
         while (gen_total - start < PHASE_ITEMS)
            random_sequence(cnt);
         settle();
      end

      repeat (6) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

### sim.f
src/bdrp_pkg.sv
src/bdrp_store.sv
src/bdrp_ctrl.sv
src/bdrp_rsp_fifo.sv
src/block_disk_register_port.sv
tb/sv/testbench.sv
